FILE: hdl/hbs_pkg.sv
package hbs_pkg;

  // Field widths fixed by the interface
  localparam int ELEV_W   = 24;
  localparam int COORD_W  = 32;
  localparam int RESULT_W = 40;
  localparam int CFG_W    = 31;

  // Request type codes
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_SAMPLE = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_GRID_SIZE  = 2'd0;
  localparam logic [1:0] CFG_WORLD_SIZE = 2'd1;
  localparam logic [1:0] CFG_ELEV_SCALE = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0]  GRID_SIZE_RST  = 8'd65;
  localparam logic [30:0] WORLD_SIZE_RST = 31'd256000;
  localparam logic [19:0] ELEV_SCALE_RST = 20'd256;

  // Elevation and result limits
  localparam logic signed [ELEV_W-1:0]   ELEV_MAX = 24'sh7FFFFF;
  localparam logic signed [ELEV_W-1:0]   ELEV_MIN = 24'sh800000;
  localparam logic signed [RESULT_W-1:0] RES_MAX  = 40'sh7FFFFFFFFF;
  localparam logic signed [RESULT_W-1:0] RES_MIN  = 40'sh8000000000;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic [6:0]                 row;
    logic [6:0]                 column;
    logic signed [ELEV_W-1:0]   elevation;
    logic signed [COORD_W-1:0]  east_west;
    logic signed [COORD_W-1:0]  north_south;
    logic signed [COORD_W-1:0]  height_offset;
  } req_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result_value;
    logic                       loaded;
    logic signed [ELEV_W-1:0]   min_elevation;
    logic signed [ELEV_W-1:0]   max_elevation;
  } rsp_t;

endpackage

FILE: hdl/hbs_ram.sv
module hbs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/heightmap_bilinear_sampler.sv
// Heightmap sampler: holds a square grid of Q15.8 elevations in one on-chip RAM and serves
// one transaction at a time. A sample on a loaded grid runs the shared compare-subtract
// divider, FRACTION_BITS+1 steps for each of the two world coordinates, then the shared
// multiplier (two grid positions, three lerps, the scale) and the four RAM reads through
// a single read port. in_ready is high only while the sequencer is idle; a finished
// result sits in the output register while the next transaction is taken.
// Configuration writes are taken at any time and must only be issued while the block is
// idle. No clearing pass is run after reset.
module heightmap_bilinear_sampler
  import hbs_pkg::*;
#(
  parameter int MAX_GRID      = 128,
  parameter int FRACTION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rsp_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int F     = FRACTION_BITS;
  localparam int CELLS = MAX_GRID * MAX_GRID;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(MAX_GRID);
  localparam int GW    = $clog2(MAX_GRID + 1);
  localparam int SW    = (GW > 8) ? GW : 8;
  localparam int CMPW  = (GW > 7) ? GW : 7;
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int LW    = (2 * GW > CNTW) ? 2 * GW : CNTW;
  localparam int MA    = (F + 2 > 26) ? F + 2 : 26;
  localparam int MB    = (F + 1 > 21) ? F + 1 : 21;
  localparam int PW    = MA + MB;
  localparam int SCW   = $clog2(F + 2);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_WRITE  = 12'b000000000010,
    ST_READ   = 12'b000000000100,
    ST_NORM   = 12'b000000001000,
    ST_DIV    = 12'b000000010000,
    ST_MUL_X  = 12'b000000100000,
    ST_MUL_Y  = 12'b000001000000,
    ST_FETCH  = 12'b000010000000,
    ST_LERP   = 12'b000100000000,
    ST_SCALE  = 12'b001000000000,
    ST_FINISH = 12'b010000000000,
    ST_OUT    = 12'b100000000000
  } state_t;

  // Row/column clamp to the grid in use
  function automatic logic [CW-1:0] clamp_idx(input logic [6:0] v, input logic [GW-1:0] lim);
    logic [CMPW-1:0] ve;
    logic [CMPW-1:0] le;
    ve = CMPW'(v);
    le = CMPW'(lim);
    return (ve > le) ? CW'(le) : CW'(ve);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(AW'(r) * AW'(MAX_GRID)) + AW'(c);
  endfunction

  state_t state_r, state_nxt;
  logic [SCW-1:0] step_r, step_nxt;

  logic [7:0]  grid_size_r;
  logic [30:0] world_size_r;
  logic [19:0] scale_r;

  req_t                     req_r;
  logic [CW-1:0]            row_r, col_r;
  logic                     axis_r;
  logic [32:0]              rem_r;
  logic [F:0]               q_r, tx_r, ty_r;
  logic [CW-1:0]            cx0_r, cx1_r, cy0_r, cy1_r;
  logic [F-1:0]             fx_r, fy_r;
  logic signed [ELEV_W-1:0] cell_r [4];
  logic signed [ELEV_W-1:0] top_r, bot_r, h_r;
  logic signed [PW-1:0]     mul_r;
  logic signed [RESULT_W-1:0] res_r;
  logic                     out_valid_r;
  rsp_t                     out_data_r;
  logic signed [ELEV_W-1:0] low_r, high_r;
  logic [CNTW-1:0]          count_r;

  // Grid size in use and load status
  logic [SW-1:0] g_ext, g_sel;
  logic [GW-1:0] gm1;
  logic [LW-1:0] g_sq;
  logic          loaded;

  always_comb begin
    g_ext = SW'(grid_size_r);
    if (g_ext < SW'(2)) begin
      g_sel = SW'(2);
    end else if (g_ext > SW'(MAX_GRID)) begin
      g_sel = SW'(MAX_GRID);
    end else begin
      g_sel = g_ext;
    end
    gm1    = GW'(g_sel - SW'(1));
    g_sq   = LW'(GW'(g_sel)) * LW'(GW'(g_sel));
    loaded = LW'(count_r) >= g_sq;
  end

  // Normalized coordinate numerator, clamped to 0..2W
  logic [30:0]        w_eff;
  logic [31:0]        den;
  logic signed [33:0] nx_raw, ny_raw, num_raw;
  logic [31:0]        num_clamped;

  always_comb begin
    w_eff   = (world_size_r == '0) ? 31'd1 : world_size_r;
    den     = {w_eff, 1'b0};
    nx_raw  = $signed({req_r.east_west[31], req_r.east_west, 1'b0}) + $signed({3'b000, w_eff});
    ny_raw  = $signed({3'b000, w_eff}) - $signed({req_r.north_south[31], req_r.north_south, 1'b0});
    num_raw = axis_r ? ny_raw : nx_raw;
    if (num_raw[33]) begin
      num_clamped = '0;
    end else if (num_raw > $signed({2'b00, den})) begin
      num_clamped = den;
    end else begin
      num_clamped = num_raw[31:0];
    end
  end

  // Divider step: one restoring compare-subtract
  logic        div_ge;
  logic [32:0] div_rem_nxt;
  logic [F:0]  div_q_nxt;

  always_comb begin
    div_ge      = rem_r >= {1'b0, den};
    div_rem_nxt = (div_ge ? (rem_r - {1'b0, den}) : rem_r) << 1;
    div_q_nxt   = {q_r[F-1:0], div_ge};
  end

  // Shared multiplier operands
  logic signed [ELEV_W:0] diff01, diff23, diff_bt, diff_hl;
  logic signed [MA-1:0]   op_a;
  logic signed [MB-1:0]   op_b;

  always_comb begin
    diff01  = (ELEV_W + 1)'(cell_r[1]) - (ELEV_W + 1)'(cell_r[0]);
    diff23  = (ELEV_W + 1)'(cell_r[3]) - (ELEV_W + 1)'(cell_r[2]);
    diff_bt = (ELEV_W + 1)'(bot_r) - (ELEV_W + 1)'(top_r);
    diff_hl = (ELEV_W + 1)'(h_r) - (ELEV_W + 1)'(low_r);
    op_a    = '0;
    op_b    = '0;
    case (state_r)
      ST_MUL_X: begin
        op_a = MA'(tx_r);
        op_b = MB'(gm1);
      end
      ST_MUL_Y: begin
        op_a = MA'(ty_r);
        op_b = MB'(gm1);
      end
      ST_LERP: begin
        if (step_r == SCW'(0)) begin
          op_a = MA'(diff01);
          op_b = MB'(fx_r);
        end else if (step_r == SCW'(1)) begin
          op_a = MA'(diff23);
          op_b = MB'(fx_r);
        end else if (step_r == SCW'(3)) begin
          op_a = MA'(diff_bt);
          op_b = MB'(fy_r);
        end
      end
      ST_SCALE: begin
        op_a = MA'(diff_hl);
        op_b = MB'(scale_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Grid position split from the product: cell and neighbor, plus the lerp step
  logic [GW-1:0]            pos_cell;
  logic [CW-1:0]            pos_c0, pos_c1;
  logic signed [ELEV_W-1:0] blend_lo;

  always_comb begin
    pos_cell = mul_r[F+GW-1:F];
    pos_c0   = (pos_cell > gm1) ? CW'(gm1) : CW'(pos_cell);
    pos_c1   = (GW'(pos_c0) < gm1) ? CW'(pos_c0 + CW'(1)) : CW'(gm1);
    blend_lo = $signed(mul_r[F+ELEV_W-1:F]);
  end

  // Final scale, offset and saturation
  logic signed [PW-1:0]       z_shift;
  logic signed [RESULT_W:0]   sum_w;
  logic signed [RESULT_W-1:0] sat_res;

  always_comb begin
    z_shift = mul_r >>> 8;
    sum_w   = (RESULT_W + 1)'(z_shift) + (RESULT_W + 1)'(req_r.height_offset);
    if (sum_w[RESULT_W] != sum_w[RESULT_W-1]) begin
      sat_res = sum_w[RESULT_W] ? RES_MIN : RES_MAX;
    end else begin
      sat_res = sum_w[RESULT_W-1:0];
    end
  end

  // RAM ports
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [ELEV_W-1:0] mem_rdata;

  always_comb begin
    mem_we    = (state_r == ST_WRITE);
    mem_waddr = cell_addr(row_r, col_r);
    mem_raddr = cell_addr(row_r, col_r);
    if (state_r == ST_FETCH) begin
      case (step_r)
        SCW'(1): mem_raddr = cell_addr(cy0_r, cx0_r);
        SCW'(2): mem_raddr = cell_addr(cy0_r, cx1_r);
        SCW'(3): mem_raddr = cell_addr(cy1_r, cx0_r);
        default: mem_raddr = cell_addr(cy1_r, cx1_r);
      endcase
    end
  end

  hbs_ram #(
    .WIDTH(ELEV_W),
    .DEPTH(CELLS)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(req_r.elevation),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  logic in_fire, out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_fire) begin
          case (in_data.req_type)
            REQ_WRITE:  state_nxt = ST_WRITE;
            REQ_READ:   state_nxt = loaded ? ST_READ : ST_OUT;
            REQ_SAMPLE: state_nxt = loaded ? ST_NORM : ST_OUT;
            default:    state_nxt = ST_OUT;
          endcase
        end
      end
      ST_WRITE: state_nxt = ST_OUT;
      ST_READ: begin
        step_nxt = step_r + SCW'(1);
        if (step_r == SCW'(1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_NORM: begin
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        step_nxt = step_r + SCW'(1);
        if (step_r == SCW'(F)) begin
          state_nxt = axis_r ? ST_MUL_X : ST_NORM;
        end
      end
      ST_MUL_X: state_nxt = ST_MUL_Y;
      ST_MUL_Y: begin
        step_nxt  = '0;
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        step_nxt = step_r + SCW'(1);
        if (step_r == SCW'(5)) begin
          step_nxt  = '0;
          state_nxt = ST_LERP;
        end
      end
      ST_LERP: begin
        step_nxt = step_r + SCW'(1);
        if (step_r == SCW'(4)) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE:  state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
      low_r        <= ELEV_MAX;
      high_r       <= ELEV_MIN;
      count_r      <= '0;
      grid_size_r  <= GRID_SIZE_RST;
      world_size_r <= WORLD_SIZE_RST;
      scale_r      <= ELEV_SCALE_RST;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_GRID_SIZE:  grid_size_r  <= cfg_wdata[7:0];
          CFG_WORLD_SIZE: world_size_r <= cfg_wdata[30:0];
          CFG_ELEV_SCALE: scale_r      <= cfg_wdata[19:0];
          default: ;
        endcase
      end
      if (state_r == ST_WRITE) begin
        if (req_r.elevation < low_r) begin
          low_r <= req_r.elevation;
        end
        if (req_r.elevation > high_r) begin
          high_r <= req_r.elevation;
        end
        if (count_r < CNTW'(CELLS)) begin
          count_r <= count_r + CNTW'(1);
        end
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mul_r <= op_a * op_b;
    unique case (state_r)
      ST_IDLE: begin
        axis_r <= 1'b0;
        if (in_fire) begin
          req_r <= in_data;
          row_r <= clamp_idx(in_data.row, gm1);
          col_r <= clamp_idx(in_data.column, gm1);
          if (in_data.req_type == REQ_SAMPLE) begin
            res_r <= RESULT_W'(in_data.height_offset);
          end else begin
            res_r <= '0;
          end
        end
      end
      ST_READ: begin
        if (step_r == SCW'(1)) begin
          res_r <= RESULT_W'($signed(mem_rdata));
        end
      end
      ST_NORM: begin
        rem_r <= {1'b0, num_clamped};
        q_r   <= '0;
      end
      ST_DIV: begin
        rem_r <= div_rem_nxt;
        q_r   <= div_q_nxt;
        if (step_r == SCW'(F)) begin
          if (axis_r) begin
            ty_r <= div_q_nxt;
          end else begin
            tx_r <= div_q_nxt;
          end
          axis_r <= 1'b1;
        end
      end
      ST_MUL_Y: begin
        cx0_r <= pos_c0;
        cx1_r <= pos_c1;
        fx_r  <= mul_r[F-1:0];
      end
      ST_FETCH: begin
        if (step_r == SCW'(0)) begin
          cy0_r <= pos_c0;
          cy1_r <= pos_c1;
          fy_r  <= mul_r[F-1:0];
        end else if (step_r >= SCW'(2)) begin
          cell_r[2'(step_r - SCW'(2))] <= $signed(mem_rdata);
        end
      end
      ST_LERP: begin
        if (step_r == SCW'(1)) begin
          top_r <= cell_r[0] + blend_lo;
        end else if (step_r == SCW'(2)) begin
          bot_r <= cell_r[2] + blend_lo;
        end else if (step_r == SCW'(4)) begin
          h_r <= top_r + blend_lo;
        end
      end
      ST_FINISH: res_r <= sat_res;
      ST_OUT: begin
        if (out_free) begin
          out_data_r.result_value  <= res_r;
          out_data_r.loaded        <= loaded;
          out_data_r.min_elevation <= low_r;
          out_data_r.max_elevation <= high_r;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // Once any cell is written, the tracked minimum never exceeds the maximum
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (low_r <= high_r))
    else $error("tracked minimum above maximum");

  // Write count saturates at the grid capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(CELLS))
    else $error("write count beyond capacity");

  // A new result is only presented from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside output state");

  // No transaction is taken while the sequencer is busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("ready while busy");
`endif

endmodule
